@@ rtl/wst_pkg.sv @@
`default_nettype none

package wst_pkg;

	// time arithmetic width, results wrap at this width
	localparam int TIME_WIDTH = 32;

	localparam int MIN_PER_HOUR  = 60;
	localparam int HOUR_PER_DAY  = 24;
	localparam int DAY_PER_WEEK  = 7;
	localparam int EPOCH_WEEKDAY = 4;
	localparam int MIN_PER_DAY   = MIN_PER_HOUR * HOUR_PER_DAY;
	localparam int MIN_PER_WEEK  = MIN_PER_DAY * DAY_PER_WEEK;
	localparam int EPOCH_SHIFT   = EPOCH_WEEKDAY * MIN_PER_DAY;

	// field widths
	localparam int START_W = 32;
	localparam int MASK_W  = 7;
	localparam int OFF_W   = 15;
	localparam int DUR_W   = 15;
	localparam int WMIN_W  = 14;

	// stream payload widths, rounded up to whole bytes
	localparam int S_DATA_W = ((START_W + MASK_W + OFF_W + DUR_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((START_W + WMIN_W + 7) / 8) * 8;

	// minute of week reduction: 10080 = 2^WEEK_SHIFT * WEEK_ODD
	localparam int WEEK_SHIFT  = 5;
	localparam int WEEK_ODD    = MIN_PER_WEEK / (2 ** WEEK_SHIFT);
	localparam int Q_W         = START_W - WEEK_SHIFT;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W     = 28;
	localparam int PROD_W      = Q_W + RECIP_W;
	localparam int QEST_W      = PROD_W - RECIP_SHIFT;
	localparam int REM_W       = 10;
	localparam int ODD_W       = 9;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) - 64'd1) / 64'(WEEK_ODD));

	typedef logic [WMIN_W-1:0] wmin_t;

endpackage

`default_nettype wire

@@ rtl/wst_week_minute.sv @@
`default_nettype none

// minute of the week for a timestamp, three register stages
module wst_week_minute import wst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [START_W-1:0] t,
	output wmin_t                   now
);

	logic [Q_W-1:0]        q_s1;
	logic [WEEK_SHIFT-1:0] lo_s1;
	logic [QEST_W-1:0]     qest_s1;
	logic [ODD_W-1:0]      rem_s2;
	logic [WEEK_SHIFT-1:0] lo_s2;
	wmin_t                 now_s3;

	logic [Q_W-1:0]    q_in;
	logic [PROD_W-1:0] prod;
	logic [REM_W-1:0]  rem_raw;
	logic [WMIN_W:0]   shifted;

	// reciprocal estimate is exact or one low
	always_comb begin
		q_in    = t[START_W-1:WEEK_SHIFT];
		prod    = PROD_W'(q_in) * PROD_W'(RECIP);
		rem_raw = REM_W'(q_s1 - Q_W'(qest_s1 * QEST_W'(WEEK_ODD)));
		shifted = (WMIN_W + 1)'({rem_s2, lo_s2}) + (WMIN_W + 1)'(EPOCH_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1    <= q_in;
			lo_s1   <= t[WEEK_SHIFT-1:0];
			qest_s1 <= prod[PROD_W-1:RECIP_SHIFT];
			lo_s2   <= lo_s1;
			if (rem_raw >= REM_W'(WEEK_ODD)) begin
				rem_s2 <= ODD_W'(rem_raw - REM_W'(WEEK_ODD));
			end else begin
				rem_s2 <= ODD_W'(rem_raw);
			end
			if (shifted >= (WMIN_W + 1)'(MIN_PER_WEEK)) begin
				now_s3 <= WMIN_W'(shifted - (WMIN_W + 1)'(MIN_PER_WEEK));
			end else begin
				now_s3 <= WMIN_W'(shifted);
			end
		end
	end

	assign now = now_s3;

endmodule

`default_nettype wire

@@ rtl/weekly_schedule_traversal_time.sv @@
// an accepted request moves stage by stage to its result on the output register
// throughput: one request per cycle unless the output stalls; the week reduction
// multiplier, the per-day wait lanes and the minimum tree are each their own stages
// a stall on the output freezes every stage, nothing is dropped or repeated
// reset (arst_n low, asynchronous) clears all stage valid bits, payload is not reset
`default_nettype none

module weekly_schedule_traversal_time import wst_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// start_time[31:0], day_mask[38:32], dep_offset[53:39],
	// travel_duration[68:54], zero fill
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// action[0], unreachable[1]
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// arrival_time[31:0], wait_minutes[45:32], zero fill
	output logic [M_DATA_W-1:0]      m_tdata,
	// skipped[0]
	output logic [0:0]               m_tuser
);

	// payload that rides along the pipe
	typedef struct packed {
		logic                  rev;
		logic                  skip;
		logic [MASK_W-1:0]     mask;
		logic [TIME_WIDTH-1:0] start;
		logic [DUR_W-1:0]      dur;
	} pay_t;

	// the whole pipe advances unless the output holds an untaken result
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// unpack the request
	logic [START_W-1:0]      in_start;
	logic [MASK_W-1:0]       in_mask;
	logic signed [OFF_W-1:0] in_offset;
	logic [DUR_W-1:0]        in_dur;
	pay_t                    in_pay;

	always_comb begin
		in_start       = s_tdata[START_W-1:0];
		in_mask        = s_tdata[START_W+MASK_W-1:START_W];
		in_offset      = s_tdata[START_W+MASK_W+OFF_W-1:START_W+MASK_W];
		in_dur         = s_tdata[START_W+MASK_W+OFF_W+DUR_W-1:START_W+MASK_W+OFF_W];
		in_pay.rev     = s_tuser[0];
		in_pay.skip    = s_tuser[1] || (in_mask == '0);
		in_pay.mask    = in_mask;
		in_pay.start   = TIME_WIDTH'(in_start);
		in_pay.dur     = in_dur;
	end

	// departure minute of each weekday, wrapped into the week
	wmin_t dep_in [DAY_PER_WEEK];

	always_comb begin
		for (int d = 0; d < DAY_PER_WEEK; d++) begin
			logic signed [16:0] v;
			logic [15:0]        u;
			v = 17'(d * MIN_PER_DAY) + 17'(in_offset);
			// bias by two weeks so the value is never negative
			u = 16'(v + 17'(2 * MIN_PER_WEEK));
			if (u >= 16'(4 * MIN_PER_WEEK)) begin
				dep_in[d] = WMIN_W'(u - 16'(4 * MIN_PER_WEEK));
			end else if (u >= 16'(3 * MIN_PER_WEEK)) begin
				dep_in[d] = WMIN_W'(u - 16'(3 * MIN_PER_WEEK));
			end else if (u >= 16'(2 * MIN_PER_WEEK)) begin
				dep_in[d] = WMIN_W'(u - 16'(2 * MIN_PER_WEEK));
			end else if (u >= 16'(MIN_PER_WEEK)) begin
				dep_in[d] = WMIN_W'(u - 16'(MIN_PER_WEEK));
			end else begin
				dep_in[d] = WMIN_W'(u);
			end
		end
	end

	// stages 1 to 3: minute of the week, departures and payload wait for it
	wmin_t now_s3;

	wst_week_minute u_week (
		.clk (clk),
		.en  (en),
		.t   (32'(in_pay.start)),
		.now (now_s3)
	);

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	pay_t  pay_s1, pay_s2, pay_s3, pay_s4, pay_s5, pay_s6;
	wmin_t dep_s1 [DAY_PER_WEEK];
	wmin_t dep_s2 [DAY_PER_WEEK];
	wmin_t dep_s3 [DAY_PER_WEEK];
	wmin_t wait_s4 [DAY_PER_WEEK];
	wmin_t lo_half_s5, hi_half_s5;
	wmin_t best_s6;
	logic [DUR_W:0] sum_s6;
	logic [START_W-1:0] arrival_s7;
	wmin_t wait_s7;
	logic  skipped_s7;

	// stage 4: wrapped wait per enabled day, disabled days read a full week
	wmin_t wait_c [DAY_PER_WEEK];

	always_comb begin
		for (int d = 0; d < DAY_PER_WEEK; d++) begin
			logic [WMIN_W:0] diff;
			if (pay_s3.rev) begin
				diff = {1'b0, now_s3} - {1'b0, dep_s3[d]};
			end else begin
				diff = {1'b0, dep_s3[d]} - {1'b0, now_s3};
			end
			if (!pay_s3.mask[d]) begin
				wait_c[d] = WMIN_W'(MIN_PER_WEEK);
			end else if (diff[WMIN_W]) begin
				wait_c[d] = WMIN_W'(diff + (WMIN_W + 1)'(MIN_PER_WEEK));
			end else begin
				wait_c[d] = WMIN_W'(diff);
			end
		end
	end

	function automatic wmin_t min2(input wmin_t a, input wmin_t b);
		return (b < a) ? b : a;
	endfunction

	// stage 7: apply wait plus travel in either direction
	logic [TIME_WIDTH-1:0] moved;

	always_comb begin
		if (pay_s6.rev) begin
			moved = pay_s6.start - TIME_WIDTH'(sum_s6);
		end else begin
			moved = pay_s6.start + TIME_WIDTH'(sum_s6);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= in_pay;
			pay_s2 <= pay_s1;
			pay_s3 <= pay_s2;
			pay_s4 <= pay_s3;
			pay_s5 <= pay_s4;
			pay_s6 <= pay_s5;
			for (int d = 0; d < DAY_PER_WEEK; d++) begin
				dep_s1[d]  <= dep_in[d];
				dep_s2[d]  <= dep_s1[d];
				dep_s3[d]  <= dep_s2[d];
				wait_s4[d] <= wait_c[d];
			end
			// stage 5: two halves of the minimum tree
			lo_half_s5 <= min2(min2(wait_s4[0], wait_s4[1]), min2(wait_s4[2], wait_s4[3]));
			hi_half_s5 <= min2(min2(wait_s4[4], wait_s4[5]), wait_s4[6]);
			// stage 6: final minimum, offset to move the start by
			best_s6 <= min2(lo_half_s5, hi_half_s5);
			sum_s6  <= (DUR_W + 1)'(min2(lo_half_s5, hi_half_s5)) + (DUR_W + 1)'(pay_s5.dur);
			// stage 7: output register, a skipped edge returns its start
			if (pay_s6.skip) begin
				arrival_s7 <= START_W'(pay_s6.start);
				wait_s7    <= '0;
				skipped_s7 <= 1'b1;
			end else begin
				arrival_s7 <= START_W'(moved);
				wait_s7    <= best_s6;
				skipped_s7 <= 1'b0;
			end
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = M_DATA_W'({wait_s7, arrival_s7});
	assign m_tuser  = skipped_s7;

endmodule

`default_nettype wire

@@ sim/weekly_schedule_traversal_time_tb.sv @@
`default_nettype none

module weekly_schedule_traversal_time_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wst_pkg::*;

	// direction of travel carried in s_tuser[0]
	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_REV = 1'b1
	} dir_t;

	// one edge evaluation request, as the driver sees it
	typedef struct packed {
		dir_t                 action;
		logic [START_W-1:0]   start_time;
		logic [MASK_W-1:0]    day_mask;
		logic [OFF_W-1:0]     dep_offset;
		logic [DUR_W-1:0]     travel_duration;
		logic                 unreachable;
	} edge_req_t;

	// one arrival as it leaves the block
	typedef struct packed {
		logic [START_W-1:0] arrival;
		wmin_t              wait_min;
		logic               skipped;
	} arrival_t;

	// directed row: request plus an arrival typed in by hand where it is obvious
	typedef struct packed {
		edge_req_t req;
		logic      typed;
		arrival_t  due;
	} dir_row_t;

	localparam int N_DIR      = 20;
	localparam int N_RAND     = 1630;
	localparam int STALL_MAX  = 5000;  // cycles with no handshake before giving up
	localparam int DRAIN_WAIT = 16;    // pipeline is 7 deep, leave some margin
	localparam int PRINT_MAX  = 100;

	localparam arrival_t NO_DUE = '0;

	// directed stimulus: skips, epoch weekday, wrap at both ends, offset and
	// duration extremes, single weekday masks in both directions
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// unreachable edge returns start unchanged
		'{'{DIR_FWD, 32'h1234_5678, 7'h7f, 15'd0, 15'd100, 1'b1}, 1'b1,
			'{32'h1234_5678, 14'd0, 1'b1}},
		// empty weekday mask also skips
		'{'{DIR_REV, 32'hffff_ffff, 7'h00, 15'd0, 15'h7fff, 1'b0}, 1'b1,
			'{32'hffff_ffff, 14'd0, 1'b1}},
		// unreachable with every other field at its top
		'{'{DIR_REV, 32'hffff_ffff, 7'h7f, 15'h3fff, 15'h7fff, 1'b1}, 1'b1,
			'{32'hffff_ffff, 14'd0, 1'b1}},
		// epoch is a thursday, departure exactly now
		'{'{DIR_FWD, 32'h0, 7'b001_0000, 15'd0, 15'd0, 1'b0}, 1'b1,
			'{32'h0, 14'd0, 1'b0}},
		// reverse below the epoch wraps to the top
		'{'{DIR_REV, 32'h0, 7'b001_0000, 15'd0, 15'd1, 1'b0}, 1'b1,
			'{32'hffff_ffff, 14'd0, 1'b0}},
		// departure one minute gone, longest forward wait
		'{'{DIR_FWD, 32'h1, 7'b001_0000, 15'd0, 15'd0, 1'b0}, 1'b1,
			'{32'd10080, 14'd10079, 1'b0}},
		// departure one minute ahead, longest reverse wait, wraps
		'{'{DIR_REV, 32'h0, 7'b001_0000, 15'd1, 15'd0, 1'b0}, 1'b1,
			'{32'hffff_d8a1, 14'd10079, 1'b0}},
		// forward past the top of the time range
		'{'{DIR_FWD, 32'hffff_ffff, 7'h7f, 15'd0, 15'h7fff, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_FWD, 32'hffff_d000, 7'h01, 15'd777, 15'h7fff, 1'b0}, 1'b0, NO_DUE},
		// offsets at a whole week either way and at the field limits
		'{'{DIR_FWD, 32'h0102_0304, 7'h7f, 15'(-10080), 15'd10, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_REV, 32'h0102_0304, 7'h55, 15'd10080, 15'd10, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_FWD, 32'h8000_0000, 7'h2a, 15'h3fff, 15'd0, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_REV, 32'h7fff_ffff, 7'h2a, 15'h4000, 15'd1, 1'b0}, 1'b0, NO_DUE},
		// one weekday at a time, sunday to saturday
		'{'{DIR_FWD, 32'd28_000_000, 7'h01, 15'd480, 15'd30, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_REV, 32'd28_000_123, 7'h02, 15'd600, 15'd45, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_FWD, 32'd28_003_000, 7'h04, 15'(-60), 15'd90, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_REV, 32'd28_007_777, 7'h08, 15'd1439, 15'd5, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_FWD, 32'd28_009_999, 7'h10, 15'd1440, 15'd0, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_REV, 32'd28_004_444, 7'h20, 15'(-1440), 15'h7fff, 1'b0}, 1'b0, NO_DUE},
		'{'{DIR_FWD, 32'd28_001_234, 7'h40, 15'd9999, 15'd1, 1'b0}, 1'b0, NO_DUE}
	};

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [1:0]          s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0]          m_tuser;

	arrival_t    arrivals_due [$];  // expected arrivals, oldest first
	arrival_t    next_arrival;      // arrival of the request now on the bus
	logic        idle_on = 1'b1;    // random gaps on both sides
	int unsigned mismatches  = 0;
	int unsigned arrived     = 0;
	int unsigned idle_cycles = 0;

	weekly_schedule_traversal_time u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// reduce any signed minute count into one week
	function automatic int week_wrap(int v);
		int m;
		m = v % MIN_PER_WEEK;
		if (m < 0) begin
			m += MIN_PER_WEEK;
		end
		return m;
	endfunction

	// arrival after waiting for the nearest scheduled departure and traveling
	function automatic arrival_t traverse_edge(edge_req_t r);
		logic [63:0] tmask;
		logic [63:0] start64;
		logic [63:0] total;
		int          now;
		int          offset;
		int          dep;
		int          w;
		int          best;
		arrival_t    res;
		tmask   = (TIME_WIDTH >= 64) ? '1 : ((64'd1 << TIME_WIDTH) - 64'd1);
		start64 = {32'd0, r.start_time} & tmask;
		if (r.unreachable || r.day_mask == '0) begin
			res.arrival  = start64[START_W-1:0];
			res.wait_min = '0;
			res.skipped  = 1'b1;
			return res;
		end
		// minute of the week, sunday midnight is zero
		now = int'(((start64 / MIN_PER_DAY) % DAY_PER_WEEK + EPOCH_WEEKDAY) % DAY_PER_WEEK)
			* MIN_PER_DAY + int'(start64 % MIN_PER_DAY);
		offset = int'($signed(r.dep_offset));
		best   = MIN_PER_WEEK;
		for (int d = 0; d < DAY_PER_WEEK; d++) begin
			if (r.day_mask[d]) begin
				dep = week_wrap(d * MIN_PER_DAY + offset);
				w   = (r.action == DIR_REV) ? week_wrap(now - dep) : week_wrap(dep - now);
				if (w < best) begin
					best = w;
				end
			end
		end
		if (r.action == DIR_REV) begin
			total = start64 - 64'(best) - 64'(r.travel_duration);
		end else begin
			total = start64 + 64'(best) + 64'(r.travel_duration);
		end
		total &= tmask;
		res.arrival  = total[START_W-1:0];
		res.wait_min = best[WMIN_W-1:0];
		res.skipped  = 1'b0;
		return res;
	endfunction

	// random request, mostly reachable with a real schedule
	function automatic edge_req_t random_request();
		edge_req_t r;
		int unsigned pick;
		r.action = dir_t'($urandom_range(1));
		pick = $urandom_range(9);
		case (pick)
			0: begin
				r.start_time = $urandom_range(20000);
			end
			1: begin
				r.start_time = 32'hffff_ffff - $urandom_range(40000);
			end
			default: begin
				r.start_time = $urandom;
			end
		endcase
		pick = $urandom_range(99);
		if (pick < 5) begin
			r.day_mask = '0;
		end else if (pick < 25) begin
			r.day_mask = MASK_W'(1) << $urandom_range(DAY_PER_WEEK - 1);
		end else begin
			r.day_mask = MASK_W'($urandom_range(127, 1));
		end
		// mostly within a week, sometimes anywhere in the field
		if ($urandom_range(9) == 0) begin
			r.dep_offset = OFF_W'($urandom);
		end else begin
			r.dep_offset = OFF_W'(int'($urandom_range(2 * MIN_PER_WEEK)) - MIN_PER_WEEK);
		end
		pick = $urandom_range(9);
		case (pick)
			0: begin
				r.travel_duration = '0;
			end
			1: begin
				r.travel_duration = '1;
			end
			2: begin
				r.travel_duration = DUR_W'($urandom_range(200));
			end
			default: begin
				r.travel_duration = DUR_W'($urandom);
			end
		endcase
		r.unreachable = ($urandom_range(99) < 8);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < PRINT_MAX) begin
			$display("[%0t] arrival %0d: %s got %0h want %0h", $realtime, arrived, what, got,
				want);
		end
		mismatches++;
	endtask

	// put one request on the bus and hold it until it is taken
	task automatic send_request(edge_req_t r, logic typed, arrival_t due);
		while (idle_on && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - START_W - MASK_W - OFF_W - DUR_W){1'b0}},
			r.travel_duration, r.dep_offset, r.day_mask, r.start_time};
		s_tuser  <= {r.unreachable, r.action};
		next_arrival = typed ? due : traverse_edge(r);
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
	endtask

	// output side backpressure, changed at the falling edge
	always @(negedge clk) begin
		m_tready <= idle_on ? ($urandom_range(99) >= 12) : 1'b1;
	end

	// check arrivals first, then record the request taken at this edge
	always @(posedge clk) begin
		arrival_t want;
		if (m_tvalid && m_tready) begin
			if (arrivals_due.size() == 0) begin
				report_mismatch("arrival with no request pending", 64'(m_tdata), '0);
			end else begin
				want = arrivals_due.pop_front();
				if (m_tdata[START_W-1:0] !== want.arrival) begin
					report_mismatch("arrival_time", 64'(m_tdata[START_W-1:0]),
						64'(want.arrival));
				end
				if (m_tdata[START_W +: WMIN_W] !== want.wait_min) begin
					report_mismatch("wait_minutes", 64'(m_tdata[START_W +: WMIN_W]),
						64'(want.wait_min));
				end
				if (m_tuser[0] !== want.skipped) begin
					report_mismatch("skipped", 64'(m_tuser[0]), 64'(want.skipped));
				end
			end
			arrived++;
		end
		if (s_tvalid && s_tready) begin
			arrivals_due.push_back(next_arrival);
		end
		// watchdog on handshakes from either side
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].due);
		end

		// random part, with a long back-to-back stretch in the middle
		for (int i = 0; i < N_RAND; i++) begin
			idle_on = !(i >= 500 && i < 800);
			send_request(random_request(), 1'b0, NO_DUE);
		end
		idle_on  = 1'b1;
		s_tvalid <= 1'b0;

		// drain, then let the pipeline settle
		while (arrivals_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
